// ----- hdl/led_matrix_row_scanner_macros.svh -----
// Assertion macros shared by the LED matrix row scanner RTL.
`ifndef LED_MATRIX_ROW_SCANNER_MACROS_SVH
`define LED_MATRIX_ROW_SCANNER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LMRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LMRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lmrs_pkg.sv -----
// Shared types and constants of the LED matrix row scanner.
package lmrs_pkg;

	localparam int ADDR_W       = 10;
	localparam int ROW_W        = 3;
	localparam int COL_W        = 6;
	localparam int IN_TDATA_W   = 16;
	localparam int IN_TUSER_W   = 2;
	localparam int OUT_FIELDS_W = 25;
	localparam int OUT_TDATA_W  = 32;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 2;

	localparam int DEF_PANELS       = 8;
	localparam int DEF_SCAN_ROWS    = 8;
	localparam int DEF_BLINK_PERIOD = 30;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [1:0] COLOR_RED   = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;

	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ON_TIME        = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_FRAMES    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UP_STEP_FRAMES = 2'd3;

	// Pixel write into one of the two column banks (top or bottom half).
	typedef struct packed {
		logic              we;
		logic              bank;
		logic [ADDR_W-1:0] addr;
		logic              data;
	} mem_wr_t;

	// Column read: the same word address is read from both banks.
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic tick;
		logic restart;
	} timer_ctl_t;

endpackage

// ----- hdl/lmrs_frame_mem.sv -----
// Two-bank pixel memory with a clearing sweep after reset.
module lmrs_frame_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  lmrs_pkg::mem_wr_t wr,
	input  lmrs_pkg::mem_rd_t rd,
	output logic             top_bit,
	output logic             bottom_bit,
	output logic             clearing
);
	import lmrs_pkg::*;

	localparam int WORDS = 1 << ADDR_W;

	logic              mem_top [WORDS];
	logic              mem_bot [WORDS];
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              we_top;
	logic              we_bot;
	logic [ADDR_W-1:0] waddr;
	logic              wdata;
	logic              top_q;
	logic              bot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {ADDR_W{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// The sweep clears the same word of both banks each cycle.
	always_comb begin
		we_top = clr_busy_q | (wr.we & ~wr.bank);
		we_bot = clr_busy_q | (wr.we & wr.bank);
		waddr  = clr_busy_q ? clr_addr_q : wr.addr;
		wdata  = clr_busy_q ? 1'b0 : wr.data;
	end

	always_ff @(posedge clk) begin
		if (we_top) begin
			mem_top[waddr] <= wdata;
		end
		if (rd.en) begin
			top_q <= mem_top[rd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_bot) begin
			mem_bot[waddr] <= wdata;
		end
		if (rd.en) begin
			bot_q <= mem_bot[rd.addr];
		end
	end

	assign top_bit    = top_q;
	assign bottom_bit = bot_q;
	assign clearing   = clr_busy_q;

endmodule

// ----- hdl/lmrs_frame_timer.sv -----
// Row index, status LED blink and scroll-step timing.
module lmrs_frame_timer #(
	parameter int SCAN_ROWS    = lmrs_pkg::DEF_SCAN_ROWS,
	parameter int BLINK_PERIOD = lmrs_pkg::DEF_BLINK_PERIOD
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lmrs_pkg::timer_ctl_t       ctl,
	input  logic [7:0]                 hold_frames,
	input  logic [7:0]                 up_step_frames,
	output logic [lmrs_pkg::ROW_W-1:0] row,
	output logic                       step,
	output logic                       led
);
	import lmrs_pkg::*;

	localparam logic [4:0] BLINK_END  = 5'(BLINK_PERIOD);
	localparam logic [4:0] BLINK_HALF = 5'(BLINK_PERIOD / 2);
	localparam logic [4:0] UP_LIMIT   = 5'd16;
	localparam logic [4:0] UP_PARKED  = 5'd17;

	logic [ROW_W-1:0] row_q;
	logic [15:0]      frame_q;
	logic [4:0]       blink_q;
	logic [4:0]       up_q;
	logic             led_q;
	logic             step_q;

	logic [ROW_W:0] row_inc;
	logic           wrap;
	logic [4:0]     blink_inc;
	logic [4:0]     blink_nxt;
	logic           led_nxt;
	logic [15:0]    frame_inc;
	logic           hold_hit;
	logic           up_hit;
	logic [4:0]     up_stepped;
	logic [4:0]     up_nxt;

	always_comb begin
		row_inc   = {1'b0, row_q} + 1'b1;
		wrap      = row_inc >= (ROW_W + 1)'(SCAN_ROWS);
		blink_inc = blink_q + 5'd1;
		blink_nxt = (blink_inc >= BLINK_END) ? 5'd0 : blink_inc;
		if (blink_nxt == 5'd0) begin
			led_nxt = 1'b1;
		end else if (blink_nxt == BLINK_HALF) begin
			led_nxt = 1'b0;
		end else begin
			led_nxt = led_q;
		end
		frame_inc  = frame_q + 16'd1;
		hold_hit   = (hold_frames != 8'd0) && (frame_inc >= {8'd0, hold_frames});
		up_hit     = (up_q < UP_LIMIT) && (frame_inc >= {8'd0, up_step_frames});
		up_stepped = up_hit ? up_q + 5'd1 : up_q;
		up_nxt     = (up_stepped == UP_LIMIT) ? UP_PARKED : up_stepped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			frame_q <= '0;
			blink_q <= '0;
			up_q    <= '0;
			led_q   <= 1'b0;
			step_q  <= 1'b0;
		end else if (ctl.tick) begin
			row_q  <= wrap ? '0 : row_inc[ROW_W-1:0];
			step_q <= 1'b0;
			if (wrap) begin
				blink_q <= blink_nxt;
				led_q   <= led_nxt;
				if (hold_hit) begin
					step_q  <= 1'b1;
					frame_q <= '0;
				end else begin
					step_q  <= up_hit;
					frame_q <= up_hit ? 16'd0 : frame_inc;
					up_q    <= up_nxt;
				end
			end
		end else if (ctl.restart) begin
			up_q <= '0;
		end
	end

	assign row  = row_q;
	assign step = step_q;
	assign led  = led_q;

endmodule

// ----- hdl/lmrs_col_shifter.sv -----
// Column sequencer: reads one column per cycle while the output is not stalled and shifts it out as a beat.
module lmrs_col_shifter #(
	parameter int PANELS = lmrs_pkg::DEF_PANELS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             start_buf,
	input  logic [lmrs_pkg::ROW_W-1:0]       row,
	input  logic                             step,
	input  logic                             led,
	input  logic [1:0]                       color_mode,
	input  logic [15:0]                      on_time,
	output lmrs_pkg::mem_rd_t                rd,
	input  logic                             top_bit,
	input  logic                             bottom_bit,
	output logic                             busy,
	output logic                             m_valid,
	input  logic                             m_ready,
	output logic [lmrs_pkg::OUT_TDATA_W-1:0] m_data,
	output logic                             m_last
);
	import lmrs_pkg::*;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(PANELS * 8 - 1);

	logic                    active_q;
	logic [COL_W-1:0]        col_q;
	logic                    buf_q;
	logic [ROW_W-1:0]        row_q;
	logic                    valid_s1;
	logic                    last_s1;
	logic                    out_valid_q;
	logic                    out_last_q;
	logic [OUT_FIELDS_W-1:0] out_data_q;

	logic                    adv;
	logic                    issue;
	logic                    red_on;
	logic                    green_on;
	logic [OUT_FIELDS_W-1:0] beat;

	always_comb begin
		adv      = ~out_valid_q | m_ready;
		issue    = active_q & adv;
		red_on   = color_mode != COLOR_GREEN;
		green_on = color_mode != COLOR_RED;
		rd.en    = issue;
		rd.addr  = {buf_q, col_q[5:3], row_q, col_q[2:0]};
		beat     = {led, last_s1 & step, last_s1 ? on_time : 16'd0, row_q,
			green_on & bottom_bit, red_on & bottom_bit,
			green_on & top_bit, red_on & top_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			col_q       <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				col_q    <= '0;
			end else if (issue) begin
				col_q <= col_q + 1'b1;
				if (col_q == LAST_COL) begin
					active_q <= 1'b0;
				end
			end
			if (adv) begin
				valid_s1    <= issue;
				last_s1     <= issue && (col_q == LAST_COL);
				out_valid_q <= valid_s1;
				out_last_q  <= last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			buf_q <= start_buf;
			row_q <= row;
		end
		if (adv && valid_s1) begin
			out_data_q <= beat;
		end
	end

	assign busy    = active_q | valid_s1;
	assign m_valid = out_valid_q;
	assign m_last  = out_last_q;
	assign m_data  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_data_q};

endmodule

// ----- hdl/led_matrix_row_scanner.sv -----
// Top level of the LED matrix row scanner.
// The block drives a multiplexed two-color LED panel from two 1-bit frame buffers.
// Input beats (s_axis) carry an opcode in tuser: a pixel write, a scan tick or a
// restart of the up-step count. Writes and restarts produce no output beat.
// A scan tick shifts out PANELS*8 column beats on m_axis, one per clock while
// m_axis_tready is high; tlast marks the final column, which also carries the
// row on-time and the scroll-step pulse. The first beat of a tick passes the column
// sequencer, the memory read register and the beat register before it is on m_axis.
// Without stalls a tick keeps the input side closed while the columns are read, one
// per cycle, and until the last one has left the memory read register.
// Writes and restarts leave the input side open.
// A stall on m_axis freezes the column sequencer and the memory read register,
// so no column is lost; the input side stays closed until the last column of
// the row has moved into the output register.
// After reset both frame buffers are cleared by a sweep over all 1024 words, one word
// of each bank per cycle, during which s_axis_tready is low. Configuration
// writes are taken at any time and should be made while the block is idle.
module led_matrix_row_scanner #(
	parameter int PANELS       = lmrs_pkg::DEF_PANELS,
	parameter int SCAN_ROWS    = lmrs_pkg::DEF_SCAN_ROWS,
	parameter int BLINK_PERIOD = lmrs_pkg::DEF_BLINK_PERIOD
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_wr_en,
	input  logic [lmrs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lmrs_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input stream.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata: buffer_select[0], pixel_address[10:1], pixel_value[11], zero fill
	input  logic [lmrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: opcode[1:0]
	input  logic [lmrs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	// Output stream.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata: red_top[0], green_top[1], red_bottom[2], green_bottom[3],
	// row_address[6:4], row_on_time[22:7], scroll_step[23], status_led[24], zero fill
	output logic [lmrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tlast
);
	import lmrs_pkg::*;

	`include "led_matrix_row_scanner_macros.svh"

	logic [1:0]  color_mode_q;
	logic [15:0] on_time_q;
	logic [7:0]  hold_frames_q;
	logic [7:0]  up_step_frames_q;

	logic             accept;
	logic [1:0]       opcode;
	logic             buffer_select;
	logic [9:0]       pixel_address;
	logic             pixel_value;
	logic             clearing;
	logic             busy;
	logic             top_bit;
	logic             bottom_bit;
	logic [ROW_W-1:0] row;
	logic             step;
	logic             led;
	mem_wr_t          wr;
	mem_rd_t          rd;
	timer_ctl_t       tctl;

	// Registers reset to zero; a write to an index is taken at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q     <= '0;
			on_time_q        <= '0;
			hold_frames_q    <= '0;
			up_step_frames_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COLOR_MODE:     color_mode_q     <= cfg_data[1:0];
				REG_ON_TIME:        on_time_q        <= cfg_data[15:0];
				REG_HOLD_FRAMES:    hold_frames_q    <= cfg_data[7:0];
				REG_UP_STEP_FRAMES: up_step_frames_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The input side opens only when the memory sweep is done and no row is
	// being read, so a write can never overtake a pending column read.
	always_comb begin
		s_axis_tready = ~clearing & ~busy;
		accept        = s_axis_tvalid & s_axis_tready;
		opcode        = s_axis_tuser[1:0];
		buffer_select = s_axis_tdata[0];
		pixel_address = s_axis_tdata[10:1];
		pixel_value   = s_axis_tdata[11];
		tctl.tick     = accept && (opcode == OP_TICK);
		tctl.restart  = accept && (opcode == OP_RESTART);
		// Address bit 6 picks the top or bottom half, i.e. the bank.
		wr.we         = accept && (opcode == OP_WRITE);
		wr.bank       = pixel_address[6];
		wr.addr       = {buffer_select, pixel_address[9:7], pixel_address[5:0]};
		wr.data       = pixel_value;
	end

	lmrs_frame_mem u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.rd         (rd),
		.top_bit    (top_bit),
		.bottom_bit (bottom_bit),
		.clearing   (clearing)
	);

	lmrs_frame_timer #(
		.SCAN_ROWS    (SCAN_ROWS),
		.BLINK_PERIOD (BLINK_PERIOD)
	) u_timer (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (tctl),
		.hold_frames    (hold_frames_q),
		.up_step_frames (up_step_frames_q),
		.row            (row),
		.step           (step),
		.led            (led)
	);

	lmrs_col_shifter #(
		.PANELS (PANELS)
	) u_shift (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (tctl.tick),
		.start_buf  (buffer_select),
		.row        (row),
		.step       (step),
		.led        (led),
		.color_mode (color_mode_q),
		.on_time    (on_time_q),
		.rd         (rd),
		.top_bit    (top_bit),
		.bottom_bit (bottom_bit),
		.busy       (busy),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_data     (m_axis_tdata),
		.m_last     (m_axis_tlast)
	);

	`LMRS_ASSERT_NEXT(a_tick_starts_scan, tctl.tick, busy, "scan tick did not start a row")
	`LMRS_ASSERT_NOW(a_no_accept_in_sweep, clearing, !s_axis_tready, "input open during sweep")
	`LMRS_ASSERT_NOW(a_tail_only_on_last, m_axis_tvalid && !m_axis_tlast,
		m_axis_tdata[23] == 1'b0 && m_axis_tdata[22:7] == 16'd0,
		"on-time or step on a non-final column")

endmodule
